@@ hdl/bps_pkg.sv @@
// Shared types and constants of the battery power supervisor.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bps_pkg;

    // Sample and counter widths
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;

    // Configuration port geometry
    localparam int CFG_DATA_BITS  = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;
    localparam int CFG_INDEX_BITS = 3;

    // Register reset values
    localparam logic [SAMPLE_BITS-1:0] STANDBY_LEVEL_RST   = SAMPLE_BITS'(12'h4F5);
    localparam logic [SAMPLE_BITS-1:0] ALERT_LEVEL_RST     = SAMPLE_BITS'(12'h585);
    localparam logic [SAMPLE_BITS-1:0] CURRENT_LEVEL_RST   = SAMPLE_BITS'(12'h050);
    localparam logic [COUNT_BITS-1:0]  STANDBY_TIMEOUT_RST = COUNT_BITS'(30000);
    localparam logic [COUNT_BITS-1:0]  CURRENT_TIMEOUT_RST = COUNT_BITS'(30000);

    // Register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_STANDBY_LEVEL   = 3'd0,
        REG_ALERT_LEVEL     = 3'd1,
        REG_CURRENT_LEVEL   = 3'd2,
        REG_STANDBY_TIMEOUT = 3'd3,
        REG_CURRENT_TIMEOUT = 3'd4
    } reg_index_t;

    // Battery zones
    typedef enum logic [1:0] {
        ZONE_STANDBY = 2'd0,
        ZONE_ALERT   = 2'd1,
        ZONE_NORMAL  = 2'd2
    } zone_t;

    // Shutdown causes
    typedef enum logic [1:0] {
        CAUSE_NONE        = 2'd0,
        CAUSE_LOW_BATTERY = 2'd1,
        CAUSE_OVERCURRENT = 2'd2
    } cause_t;

    // Current configuration, from the register file to the core
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] standby_level;
        logic [SAMPLE_BITS-1:0] alert_level;
        logic [SAMPLE_BITS-1:0] current_level;
        logic [COUNT_BITS-1:0]  standby_timeout;
        logic [COUNT_BITS-1:0]  current_timeout;
    } cfg_t;

    // One supervision tick
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] battery_sample;
        logic [SAMPLE_BITS-1:0] current_sample;
        logic                   accessory_level;
    } sample_t;

    // One result
    typedef struct packed {
        logic                   power_enable;
        logic [SAMPLE_BITS-1:0] battery_average;
        logic [SAMPLE_BITS-1:0] current_average;
        zone_t                  zone;
        cause_t                 shutdown_cause;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/bps_sample_if.sv @@
// Input channel of the battery power supervisor: valid/ready plus one tick.
// Depends on bps_pkg for the sample width.
`default_nettype none

interface bps_sample_if;
    import bps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] battery_sample;
    logic [SAMPLE_BITS-1:0] current_sample;
    logic                   accessory_level;

    modport source (output valid, output battery_sample, output current_sample,
                    output accessory_level, input ready);
    modport sink   (input valid, input battery_sample, input current_sample,
                    input accessory_level, output ready);
endinterface

`default_nettype wire

@@ hdl/bps_result_if.sv @@
// Output channel of the battery power supervisor: valid/ready plus one result.
// Depends on bps_pkg for the sample width.
`default_nettype none

interface bps_result_if;
    import bps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   power_enable;
    logic [SAMPLE_BITS-1:0] battery_average;
    logic [SAMPLE_BITS-1:0] current_average;
    logic [1:0]             zone;
    logic [1:0]             shutdown_cause;

    modport source (output valid, output power_enable, output battery_average,
                    output current_average, output zone, output shutdown_cause,
                    input ready);
    modport sink   (input valid, input power_enable, input battery_average,
                    input current_average, input zone, input shutdown_cause,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/bps_cfg_regs.sv @@
// Configuration register file of the battery power supervisor.
// Depends on bps_pkg for widths, reset values and register indexes.
`default_nettype none

module bps_cfg_regs (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                wr_en,
    input  wire [bps_pkg::CFG_INDEX_BITS-1:0]  wr_index,
    input  wire [bps_pkg::CFG_DATA_BITS-1:0]   wr_data,
    output bps_pkg::cfg_t                      cfg
);
    import bps_pkg::*;

    logic [SAMPLE_BITS-1:0] standby_level_reg;
    logic [SAMPLE_BITS-1:0] alert_level_reg;
    logic [SAMPLE_BITS-1:0] current_level_reg;
    logic [COUNT_BITS-1:0]  standby_timeout_reg;
    logic [COUNT_BITS-1:0]  current_timeout_reg;

    // Register writes keep only each register's width; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            standby_level_reg   <= STANDBY_LEVEL_RST;
            alert_level_reg     <= ALERT_LEVEL_RST;
            current_level_reg   <= CURRENT_LEVEL_RST;
            standby_timeout_reg <= STANDBY_TIMEOUT_RST;
            current_timeout_reg <= CURRENT_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_STANDBY_LEVEL:   standby_level_reg   <= wr_data[SAMPLE_BITS-1:0];
                REG_ALERT_LEVEL:     alert_level_reg     <= wr_data[SAMPLE_BITS-1:0];
                REG_CURRENT_LEVEL:   current_level_reg   <= wr_data[SAMPLE_BITS-1:0];
                REG_STANDBY_TIMEOUT: standby_timeout_reg <= wr_data[COUNT_BITS-1:0];
                REG_CURRENT_TIMEOUT: current_timeout_reg <= wr_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.standby_level   = standby_level_reg;
    assign cfg.alert_level     = alert_level_reg;
    assign cfg.current_level   = current_level_reg;
    assign cfg.standby_timeout = standby_timeout_reg;
    assign cfg.current_timeout = current_timeout_reg;

endmodule

`default_nettype wire

@@ hdl/bps_core.sv @@
// Supervision state and per-tick logic: smoothing, zoning, counters, latch.
// Depends on bps_pkg; driven by the pipeline in the top level.
`default_nettype none

module bps_core (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    step,
    input  wire bps_pkg::cfg_t     cfg,
    input  wire bps_pkg::sample_t  sample,
    output bps_pkg::result_t       result
);
    import bps_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [SAMPLE_BITS-1:0] bat_avg_reg, bat_avg_next;
    logic [SAMPLE_BITS-1:0] cur_avg_reg, cur_avg_next;
    logic [COUNT_BITS-1:0]  standby_count_reg, standby_count_next;
    logic [COUNT_BITS-1:0]  oc_count_reg, oc_count_next;
    logic                   power_on_reg, power_on_next;
    logic [SAMPLE_BITS:0]   bat_sum;
    logic [SAMPLE_BITS:0]   cur_sum;
    zone_t                  zone_next;
    cause_t                 cause_next;

    // Saturating increment
    function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
        count_up = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_BITS'(1);
    endfunction

    // Smoothing: floor of old plus new, halved
    assign bat_sum      = {1'b0, bat_avg_reg} + {1'b0, sample.battery_sample};
    assign cur_sum      = {1'b0, cur_avg_reg} + {1'b0, sample.current_sample};
    assign bat_avg_next = bat_sum[SAMPLE_BITS:1];
    assign cur_avg_next = cur_sum[SAMPLE_BITS:1];

    // Zone classification and persistence counters
    always_comb
    begin
        standby_count_next = '0;
        oc_count_next      = '0;
        power_on_next      = power_on_reg;
        cause_next         = CAUSE_NONE;
        if (bat_avg_next < cfg.standby_level)
        begin
            zone_next = ZONE_STANDBY;
            if (standby_count_reg > cfg.standby_timeout)
            begin
                power_on_next = 1'b0;
                cause_next    = CAUSE_LOW_BATTERY;
            end
            else
            begin
                standby_count_next = count_up(standby_count_reg);
            end
        end
        else if (bat_avg_next < cfg.alert_level)
        begin
            zone_next = ZONE_ALERT;
            if (!sample.accessory_level || cur_avg_next <= cfg.current_level)
            begin
                oc_count_next = '0;
            end
            else if (oc_count_reg < cfg.current_timeout)
            begin
                oc_count_next = count_up(oc_count_reg);
            end
            else
            begin
                power_on_next = 1'b0;
                cause_next    = CAUSE_OVERCURRENT;
            end
        end
        else
        begin
            zone_next = ZONE_NORMAL;
        end
    end

    // State update, once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bat_avg_reg       <= '0;
            cur_avg_reg       <= '0;
            standby_count_reg <= '0;
            oc_count_reg      <= '0;
            power_on_reg      <= 1'b1;
        end
        else if (step)
        begin
            bat_avg_reg       <= bat_avg_next;
            cur_avg_reg       <= cur_avg_next;
            standby_count_reg <= standby_count_next;
            oc_count_reg      <= oc_count_next;
            power_on_reg      <= power_on_next;
        end
    end

    assign result.power_enable    = power_on_next;
    assign result.battery_average = bat_avg_next;
    assign result.current_average = cur_avg_next;
    assign result.zone            = zone_next;
    assign result.shutdown_cause  = cause_next;

    // Power latch never comes back on without reset
    a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !power_on_reg |=> !power_on_reg)
        else $error("power latch turned back on");

    // A trip leaves power off
    a_trip_off: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cause_next != CAUSE_NONE) |=> !power_on_reg)
        else $error("trip did not clear the power latch");

    // Only one persistence counter runs at a time
    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        !(standby_count_reg != '0 && oc_count_reg != '0))
        else $error("both persistence counters are running");

endmodule

`default_nettype wire

@@ hdl/battery_power_supervisor.sv @@
// Top level of the battery power supervisor: input register, core, result register.
// Depends on bps_pkg, bps_sample_if, bps_result_if, bps_cfg_regs and bps_core.
//
//   channel    | dir  | transfer
//   -----------+------+--------------------------------------------------
//   sample_ch  | sink | one tick: battery, current, accessory level
//   result_ch  | src  | one result per tick: power, averages, zone, cause
//   wr_*       | in   | register write, taken when wr_en is high
//
// One tick per clock sustained while result_ch takes each result; a tick passes
// through the input register, then through the core logic into the result register,
// which offers it on result_ch.
// Reset clears the smoothing and counters, sets power on, loads register defaults.
// A stalled result register holds the tick in the input register; once both are
// full the input channel drops ready, and nothing is lost.
`default_nettype none

module battery_power_supervisor (
    input  wire                               clk,
    input  wire                               rst_n,
    bps_sample_if.sink                        sample_ch,
    bps_result_if.source                      result_ch,
    input  wire                               wr_en,
    input  wire [bps_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  wire [bps_pkg::CFG_DATA_BITS-1:0]  wr_data
);
    import bps_pkg::*;

    cfg_t    cfg;
    sample_t stage_data_reg;
    logic    stage_valid_reg, stage_valid_next;
    result_t core_result;
    result_t result_data_reg;
    logic    result_valid_reg, result_valid_next;
    logic    advance;
    logic    accept;
    logic    step;

    bps_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Pipeline control
    assign advance         = !result_valid_reg || result_ch.ready;
    assign sample_ch.ready = !stage_valid_reg || advance;
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign step            = stage_valid_reg && advance;

    always_comb
    begin
        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;

        if (step)
            result_valid_next = 1'b1;
        else if (result_ch.ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_data_reg.battery_sample  <= sample_ch.battery_sample;
            stage_data_reg.current_sample  <= sample_ch.current_sample;
            stage_data_reg.accessory_level <= sample_ch.accessory_level;
        end
    end

    bps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg),
        .sample (stage_data_reg),
        .result (core_result)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (step)
            result_data_reg <= core_result;
    end

    assign result_ch.valid           = result_valid_reg;
    assign result_ch.power_enable    = result_data_reg.power_enable;
    assign result_ch.battery_average = result_data_reg.battery_average;
    assign result_ch.current_average = result_data_reg.current_average;
    assign result_ch.zone            = result_data_reg.zone;
    assign result_ch.shutdown_cause  = result_data_reg.shutdown_cause;

    // A full, stalled pipeline takes no new tick
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && result_valid_reg && !result_ch.ready) |-> !sample_ch.ready)
        else $error("input taken while the pipeline is full");

    // A processed tick shows up as a result in the next cycle
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> result_valid_reg)
        else $error("processed tick produced no result");

endmodule

`default_nettype wire
